// File: hw/rtl/pfcp_pkg.sv
// shared constants and types for the pulse frame capture packetizer
`timescale 1ns / 1ps
package pfcp_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int WIDTH_W          = 16;
	localparam int BYTE_W           = 8;

	localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RESET = 16'd4000;

	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [BYTE_W-1:0]  byte_t;

	// packet buffer status seen by the capture logic
	typedef struct packed {
		logic busy;
	} buf_stat_t;

endpackage

// File: hw/rtl/pfcp_pkt_buf.sv
// packet byte buffer: loads captured widths and shifts packet bytes out
`timescale 1ns / 1ps
module pfcp_pkt_buf
	import pfcp_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  width_t    load_widths [NUM_CHANNELS],
	output buf_stat_t stat,
	output logic      out_valid,
	input  logic      out_ready,
	output byte_t     packet_byte,
	output logic      last_byte
);

	localparam int NB   = 2 * NUM_CHANNELS + 1;
	localparam int CNTW = $clog2(NB + 1);

	byte_t           bytes_q [NB];
	byte_t           new_bytes [NB];
	logic [CNTW-1:0] count_q;
	logic            pop;

	// assemble packet: high byte, low byte per channel, then running xor
	always_comb begin
		byte_t sum;
		sum = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			new_bytes[2*k]   = load_widths[k][15:8];
			new_bytes[2*k+1] = load_widths[k][7:0];
			sum = sum ^ load_widths[k][15:8] ^ load_widths[k][7:0];
		end
		new_bytes[NB-1] = sum;
	end

	assign pop = out_valid && out_ready;

	// byte shift line, head is the output
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= new_bytes;
		end else if (pop) begin
			for (int k = 0; k < NB - 1; k++) begin
				bytes_q[k] <= bytes_q[k+1];
			end
		end
	end

	// remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= CNTW'(NB);
		end else if (pop) begin
			count_q <= count_q - CNTW'(1);
		end
	end

	assign out_valid   = (count_q != '0);
	assign last_byte   = (count_q == CNTW'(1));
	assign packet_byte = bytes_q[0];
	assign stat.busy   = out_valid;

endmodule

// File: hw/rtl/pulse_frame_capture_packetizer.sv
// top level: pulse width timing, frame sync and packet capture
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_ready  | line_level
//  out     | out_valid / out_ready| packet_byte, last_byte
//  cfg     | cfg_valid / cfg_ready| cfg_data (sync_threshold)
//
// one line sample is taken per cycle while in_ready; the sample that
// closes the last channel's high period loads a 2*NUM_CHANNELS+1 byte
// packet into the output buffer, whose first byte shows in the cycle
// after that sample; it then drains one byte per cycle while out_ready.
// in_ready drops only when the next sample could close a packet while
// the previous packet is still draining.
// reset (arst_n low) clears all control state and loads sync_threshold 4000.
// cfg writes are taken in any cycle.
`timescale 1ns / 1ps
module pulse_frame_capture_packetizer
	import pfcp_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         line_level,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   packet_byte,
	output logic         last_byte,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	localparam int CIW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CMPW = (COUNT_WIDTH > WIDTH_W) ? COUNT_WIDTH : WIDTH_W;
	localparam logic [CIW-1:0] LAST_CH = CIW'(NUM_CHANNELS - 1);

	width_t                 threshold_q;
	logic                   synced_q;
	logic                   prev_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [CIW-1:0]         chan_q;
	width_t                 widths_q [NUM_CHANNELS];

	width_t                 load_widths [NUM_CHANNELS];
	width_t                 period_w;
	logic                   accept;
	logic                   period_end;
	logic                   over_thr;
	logic                   load;
	buf_stat_t              stat;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= SYNC_THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			threshold_q <= cfg_data;
		end
	end

	// hold off a request that could close a packet while one drains
	assign in_ready   = !(stat.busy && synced_q && prev_q && (chan_q == LAST_CH));
	assign accept     = in_valid && in_ready;
	assign period_end = !line_level && prev_q;
	assign period_w   = WIDTH_W'(count_q);
	assign over_thr   = CMPW'(count_q) > CMPW'(threshold_q);
	assign load       = accept && period_end && synced_q && (chan_q == LAST_CH);

	// pulse timing and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			prev_q   <= 1'b0;
			count_q  <= '0;
			chan_q   <= '0;
		end else if (accept) begin
			prev_q <= line_level;
			if (line_level) begin
				if (count_q != '1) begin
					count_q <= count_q + COUNT_WIDTH'(1);
				end
			end else if (prev_q) begin
				count_q <= '0;
				if (!synced_q) begin
					if (over_thr) begin
						synced_q <= 1'b1;
						chan_q   <= '0;
					end
				end else if (chan_q == LAST_CH) begin
					synced_q <= 1'b0;
					chan_q   <= '0;
				end else begin
					chan_q <= chan_q + CIW'(1);
				end
			end
		end
	end

	// captured channel widths
	always_ff @(posedge clk) begin
		if (accept && period_end && synced_q) begin
			widths_q[chan_q] <= period_w;
		end
	end

	// last channel's width goes straight into the packet
	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			load_widths[k] = (k == NUM_CHANNELS - 1) ? period_w : widths_q[k];
		end
	end

	pfcp_pkt_buf #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_pkt_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_widths(load_widths),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.packet_byte(packet_byte),
		.last_byte  (last_byte)
	);

endmodule

// File: hw/rtl/pfcp_checker.sv
// port level checks for the pulse frame capture packetizer
`timescale 1ns / 1ps
module pfcp_checker
	import pfcp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packet_byte,
	input logic       last_byte
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packet_byte) && $stable(last_byte))
		else $error("stalled result changed");

	// packet ends after its marked byte
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !out_valid)
		else $error("result right after last byte");

	// packet bytes continue until the marked one
	a_no_gap_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> out_valid)
		else $error("packet cut short");

	// input stalls only while a packet drains
	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind pulse_frame_capture_packetizer pfcp_checker u_pfcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.packet_byte(packet_byte),
	.last_byte  (last_byte)
);
